// ===== design/tcd_pkg.sv =====
// Shared types, character codes and prefix tables for the text command decoder.
// No dependencies.
package tcd_pkg;

  localparam int CHAR_W  = 8;
  localparam int TICK_W  = 32;
  localparam int VALUE_W = 32;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 3;
  localparam int COUNT_W = 4;
  localparam int PHASE_W = 4;
  localparam int DIGIT_W = 4;

  localparam int TEST_DIGIT_LIMIT   = 7;
  localparam int ROTATE_DIGIT_LIMIT = 10;

  localparam logic [POS_W-1:0] LED_PREFIX_LEN  = POS_W'(4);
  localparam logic [POS_W-1:0] TEST_PREFIX_LEN = POS_W'(5);
  localparam logic [POS_W-1:0] ROT_PREFIX_LEN  = POS_W'(7);

  localparam logic [KIND_W-1:0] KIND_LED    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEST   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROTATE = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
  localparam logic [CHAR_W-1:0] CH_L     = 8'h6c;
  localparam logic [CHAR_W-1:0] CH_N     = 8'h6e;
  localparam logic [CHAR_W-1:0] CH_O     = 8'h6f;
  localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h74;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [TICK_W-1:0] tick_time;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [KIND_W-1:0]  command_kind;
    logic [VALUE_W-1:0] value;
    logic [TICK_W-1:0]  stamp;
  } result_t;

  typedef struct packed {
    logic take;
    logic term;
  } stage_ctl_t;

  function automatic logic [CHAR_W-1:0] led_char(input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h6c;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h64;
      3'd3:    c = CH_SPACE;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] test_char(input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h74;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h73;
      3'd3:    c = 8'h74;
      3'd4:    c = CH_SPACE;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] rot_char(input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h72;
      3'd1:    c = 8'h6f;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h74;
      3'd5:    c = 8'h65;
      3'd6:    c = CH_SPACE;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ===== design/tcd_input_stage.sv =====
// Input register of the text command decoder: holds one character transaction.
// Depends on tcd_pkg.
module tcd_input_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  logic [7:0]          char_code,
  input  logic [31:0]         tick_time,
  input  logic                slot_free,
  output tcd_pkg::item_t      item,
  output tcd_pkg::stage_ctl_t ctl
);

  logic full;
  logic term;
  logic take;

  assign term       = full && (item.char_code == tcd_pkg::CH_NUL);
  assign take       = full && (!term || slot_free);
  assign char_stall = full && !take;
  assign ctl.take   = take;
  assign ctl.term   = term;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!full || take) begin
      full <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && (!full || take)) begin
      item.char_code <= char_code;
      item.tick_time <= tick_time;
    end
  end

endmodule

// ===== design/tcd_parser.sv =====
// Parse state machine and number accumulator; forms the result on the terminator.
// Depends on tcd_pkg.
module tcd_parser #(
  parameter int TEST_DIGIT_LIMIT   = tcd_pkg::TEST_DIGIT_LIMIT,
  parameter int ROTATE_DIGIT_LIMIT = tcd_pkg::ROTATE_DIGIT_LIMIT
) (
  input  logic                clk,
  input  logic                rst,
  input  tcd_pkg::item_t      item,
  input  tcd_pkg::stage_ctl_t ctl,
  output tcd_pkg::result_t    result
);

  localparam logic [tcd_pkg::PHASE_W-1:0] PH_FIRST     = 4'd0;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_LED_PRE   = 4'd1;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_TEST_PRE  = 4'd2;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_ROT_PRE   = 4'd3;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_LED_DIGIT = 4'd4;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_LED_SPACE = 4'd5;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_LED_WORD  = 4'd6;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_LED_O     = 4'd7;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_LED_OF    = 4'd8;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_LED_END   = 4'd9;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_TEST_NUM  = 4'd10;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_ROT_SIGN  = 4'd11;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_ROT_NUM   = 4'd12;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_NUM_DONE  = 4'd13;
  localparam logic [tcd_pkg::PHASE_W-1:0] PH_REJECT    = 4'd14;

  localparam logic [tcd_pkg::COUNT_W-1:0] TEST_LIMIT =
    tcd_pkg::COUNT_W'(TEST_DIGIT_LIMIT);
  localparam logic [tcd_pkg::COUNT_W-1:0] ROT_LIMIT =
    tcd_pkg::COUNT_W'(ROTATE_DIGIT_LIMIT);

  logic [tcd_pkg::PHASE_W-1:0] phase, phase_next;
  logic [tcd_pkg::POS_W-1:0]   pos, pos_next;
  logic [31:0]                 sum, sum_next;
  logic                        minus, minus_next;
  logic [tcd_pkg::COUNT_W-1:0] count, count_next;
  logic [3:0]                  lamp, lamp_next;
  logic                        lamp_on, lamp_on_next;
  logic                        test_cmd, test_cmd_next;

  logic [7:0]                  c;
  logic                        num_char;
  logic [tcd_pkg::DIGIT_W-1:0] digit;
  logic [31:0]                 sum_step;
  logic [tcd_pkg::COUNT_W-1:0] count_inc;
  logic [tcd_pkg::COUNT_W-1:0] limit;
  logic                        num_phase;

  assign c         = item.char_code;
  assign num_char  = (c >= tcd_pkg::CH_ZERO) && (c <= tcd_pkg::CH_NINE);
  assign digit     = tcd_pkg::DIGIT_W'(c - tcd_pkg::CH_ZERO);
  assign sum_step  = {sum[28:0], 3'b000} + {sum[30:0], 1'b0} + 32'(digit);
  assign count_inc = count + 4'd1;
  assign limit     = test_cmd ? TEST_LIMIT : ROT_LIMIT;
  assign num_phase = (phase == PH_TEST_NUM) || (phase == PH_ROT_NUM) ||
                     (phase == PH_NUM_DONE);

  always_comb begin
    result.accepted     = 1'b0;
    result.command_kind = tcd_pkg::KIND_LED;
    result.value        = '0;
    result.stamp        = item.tick_time;
    if (phase == PH_LED_END) begin
      result.accepted = 1'b1;
      result.value    = 32'({lamp, lamp_on});
    end else if (num_phase && (sum != '0)) begin
      result.accepted = 1'b1;
      if (test_cmd) begin
        result.command_kind = tcd_pkg::KIND_TEST;
        result.value        = sum;
      end else begin
        result.command_kind = tcd_pkg::KIND_ROTATE;
        result.value        = minus ? (32'd0 - sum) : sum;
      end
    end
  end

  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    sum_next      = sum;
    minus_next    = minus;
    count_next    = count;
    lamp_next     = lamp;
    lamp_on_next  = lamp_on;
    test_cmd_next = test_cmd;
    if (ctl.term) begin
      phase_next    = PH_FIRST;
      pos_next      = '0;
      sum_next      = '0;
      minus_next    = 1'b0;
      count_next    = '0;
      lamp_next     = '0;
      lamp_on_next  = 1'b0;
      test_cmd_next = 1'b0;
    end else begin
      unique case (phase) inside
        PH_FIRST: begin
          pos_next = 3'd1;
          if (c == tcd_pkg::CH_L) begin
            phase_next = PH_LED_PRE;
          end else if (c == tcd_pkg::CH_T) begin
            phase_next = PH_TEST_PRE;
          end else if (c == tcd_pkg::CH_R) begin
            phase_next = PH_ROT_PRE;
          end else begin
            phase_next = PH_REJECT;
          end
        end
        PH_LED_PRE: begin
          if (c == tcd_pkg::led_char(pos)) begin
            pos_next = pos + 3'd1;
            if (pos_next == tcd_pkg::LED_PREFIX_LEN) phase_next = PH_LED_DIGIT;
          end else begin
            phase_next = PH_REJECT;
          end
        end
        PH_TEST_PRE: begin
          test_cmd_next = 1'b1;
          if (c == tcd_pkg::test_char(pos)) begin
            pos_next = pos + 3'd1;
            if (pos_next == tcd_pkg::TEST_PREFIX_LEN) phase_next = PH_TEST_NUM;
          end else begin
            phase_next = PH_REJECT;
          end
        end
        PH_ROT_PRE: begin
          if (c == tcd_pkg::rot_char(pos)) begin
            pos_next = pos + 3'd1;
            if (pos_next == tcd_pkg::ROT_PREFIX_LEN) phase_next = PH_ROT_SIGN;
          end else begin
            phase_next = PH_REJECT;
          end
        end
        PH_LED_DIGIT: begin
          if (num_char) begin
            lamp_next  = digit;
            phase_next = PH_LED_SPACE;
          end else begin
            phase_next = PH_REJECT;
          end
        end
        PH_LED_SPACE: begin
          phase_next = (c == tcd_pkg::CH_SPACE) ? PH_LED_WORD : PH_REJECT;
        end
        PH_LED_WORD: begin
          phase_next = (c == tcd_pkg::CH_O) ? PH_LED_O : PH_REJECT;
        end
        PH_LED_O: begin
          if (c == tcd_pkg::CH_N) begin
            lamp_on_next = 1'b1;
            phase_next   = PH_LED_END;
          end else if (c == tcd_pkg::CH_F) begin
            phase_next = PH_LED_OF;
          end else begin
            phase_next = PH_REJECT;
          end
        end
        PH_LED_OF: begin
          if (c == tcd_pkg::CH_F) begin
            lamp_on_next = 1'b0;
            phase_next   = PH_LED_END;
          end else begin
            phase_next = PH_REJECT;
          end
        end
        PH_LED_END: begin
          phase_next = PH_REJECT;
        end
        PH_TEST_NUM, PH_ROT_NUM: begin
          if (!num_char) begin
            phase_next = PH_NUM_DONE;
          end else begin
            sum_next   = sum_step;
            count_next = count_inc;
            if (count_inc >= limit) phase_next = PH_NUM_DONE;
          end
        end
        PH_ROT_SIGN: begin
          if (c == tcd_pkg::CH_MINUS) begin
            minus_next = 1'b1;
            phase_next = PH_ROT_NUM;
          end else if (num_char) begin
            sum_next   = sum_step;
            count_next = count_inc;
            phase_next = (count_inc >= limit) ? PH_NUM_DONE : PH_ROT_NUM;
          end else begin
            phase_next = PH_REJECT;
          end
        end
        PH_NUM_DONE: begin
          phase_next = PH_NUM_DONE;
        end
        default: begin
          phase_next = PH_REJECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FIRST;
      pos      <= '0;
      sum      <= '0;
      minus    <= 1'b0;
      count    <= '0;
      lamp     <= '0;
      lamp_on  <= 1'b0;
      test_cmd <= 1'b0;
    end else if (ctl.take) begin
      phase    <= phase_next;
      pos      <= pos_next;
      sum      <= sum_next;
      minus    <= minus_next;
      count    <= count_next;
      lamp     <= lamp_next;
      lamp_on  <= lamp_on_next;
      test_cmd <= test_cmd_next;
    end
  end

endmodule

// ===== design/tcd_result_stage.sv =====
// Result register of the text command decoder: holds one result transaction.
// Depends on tcd_pkg.
module tcd_result_stage (
  input  logic                clk,
  input  logic                rst,
  input  tcd_pkg::stage_ctl_t ctl,
  input  tcd_pkg::result_t    result,
  output logic                slot_free,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                accepted,
  output logic [1:0]          command_kind,
  output logic signed [31:0]  value,
  output logic [31:0]         stamp
);

  logic load;

  assign slot_free = !result_valid || !result_stall;
  assign load      = ctl.take && ctl.term;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      accepted     <= result.accepted;
      command_kind <= result.command_kind;
      value        <= signed'(result.value);
      stamp        <= result.stamp;
    end
  end

endmodule

// ===== design/text_command_decoder_unit.sv =====
// Top level of the text command decoder.
// Depends on tcd_pkg, tcd_input_stage, tcd_parser and tcd_result_stage.

// Takes one character per cycle, sustained, through a valid/stall input
// register; a zero character ends the command and, in the cycle after it is
// taken, its single result appears in the output register. Characters other
// than the terminator never wait on the output side; a terminator waits in
// the input register only while an earlier result is still held there.
module text_command_decoder_unit #(
  parameter int TEST_DIGIT_LIMIT   = tcd_pkg::TEST_DIGIT_LIMIT,
  parameter int ROTATE_DIGIT_LIMIT = tcd_pkg::ROTATE_DIGIT_LIMIT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         char_code,
  input  logic [31:0]        tick_time,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               accepted,
  output logic [1:0]         command_kind,
  output logic signed [31:0] value,
  output logic [31:0]        stamp
);

  tcd_pkg::item_t      item;
  tcd_pkg::stage_ctl_t ctl;
  tcd_pkg::result_t    result;
  logic                slot_free;

  tcd_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .tick_time  (tick_time),
    .slot_free  (slot_free),
    .item       (item),
    .ctl        (ctl)
  );

  tcd_parser #(
    .TEST_DIGIT_LIMIT   (TEST_DIGIT_LIMIT),
    .ROTATE_DIGIT_LIMIT (ROTATE_DIGIT_LIMIT)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctl    (ctl),
    .result (result)
  );

  tcd_result_stage u_result (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .result       (result),
    .slot_free    (slot_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accepted     (accepted),
    .command_kind (command_kind),
    .value        (value),
    .stamp        (stamp)
  );

endmodule

// ===== tb/text_command_decoder_unit_test.sv =====
// Self-checking testbench for text_command_decoder_unit: commands go in one character
// per transaction and every reply is checked against a bench decoder or directed table.
// Depends on tcd_pkg and the design sources only.
module text_command_decoder_unit_test;

  typedef enum logic [3:0] {
    PH_FIRST, PH_LED_PRE, PH_TEST_PRE, PH_ROT_PRE, PH_LED_DIGIT, PH_LED_SPACE,
    PH_LED_WORD, PH_LED_O, PH_LED_OF, PH_LED_END, PH_TEST_NUM, PH_ROT_SIGN,
    PH_ROT_NUM, PH_NUM_DONE, PH_REJECT
  } phase_t;

  typedef struct {
    string            text;
    bit               typed;
    tcd_pkg::result_t reply;
  } directed_row_t;

  localparam int               N_DIRECTED = 18;
  localparam int               RANDOM_CHARS = 400;
  localparam int               HOLD_CYCLES = 300;
  localparam tcd_pkg::result_t REJECTED = '{1'b0, tcd_pkg::KIND_LED, 32'd0, 32'd0};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               char_valid = 1'b0;
  logic               char_stall;
  logic [7:0]         char_code = 8'd0;
  logic [31:0]        tick_time = 32'd0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               accepted;
  logic [1:0]         command_kind;
  logic signed [31:0] value;
  logic [31:0]        stamp;

  text_command_decoder_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .tick_time    (tick_time),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accepted     (accepted),
    .command_kind (command_kind),
    .value        (value),
    .stamp        (stamp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // decoder state
  phase_t      cmd_phase = PH_FIRST;
  int          prefix_pos = 0;
  logic [31:0] acc_sum = 32'd0;
  bit          neg_sign = 1'b0;
  int          digit_count = 0;
  logic [3:0]  lamp_idx = 4'd0;
  bit          lamp_state = 1'b0;
  bit          is_test = 1'b0;

  tcd_pkg::result_t awaited_replies[$];
  directed_row_t    directed_rows[N_DIRECTED];

  int chars_sent = 0;
  int commands_sent = 0;
  int replies_seen = 0;
  int replies_ok = 0;
  int kind_seen[3] = '{0, 0, 0};
  int fail_count = 0;
  int reports = 0;
  bit tx_quiet = 1'b0;
  bit hold_off = 1'b0;
  bit pressure_req = 1'b0;

  function automatic tcd_pkg::result_t accepted_reply(logic [1:0] kind, logic [31:0] val);
    return '{1'b1, kind, val, 32'd0};
  endfunction

  function automatic bit num_char(logic [7:0] c);
    return c >= tcd_pkg::CH_ZERO && c <= tcd_pkg::CH_NINE;
  endfunction

  function automatic void clear_parse();
    cmd_phase = PH_FIRST;
    prefix_pos = 0;
    acc_sum = 32'd0;
    neg_sign = 1'b0;
    digit_count = 0;
    lamp_idx = 4'd0;
    lamp_state = 1'b0;
    is_test = 1'b0;
  endfunction

  function automatic void match_prefix(logic [7:0] c, string word, phase_t next);
    if (prefix_pos < word.len() && c == word[prefix_pos]) begin
      prefix_pos++;
      if (prefix_pos == word.len()) cmd_phase = next;
    end else begin
      cmd_phase = PH_REJECT;
    end
  endfunction

  function automatic void take_digit(logic [7:0] c, int limit);
    if (!num_char(c)) begin
      cmd_phase = PH_NUM_DONE;
    end else begin
      acc_sum = acc_sum * 32'd10 + {24'd0, c - tcd_pkg::CH_ZERO};
      digit_count++;
      if (digit_count >= limit) cmd_phase = PH_NUM_DONE;
    end
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic [31:0] t,
                                      output bit emits, output tcd_pkg::result_t res);
    emits = 1'b0;
    res = REJECTED;
    if (c == tcd_pkg::CH_NUL) begin
      emits = 1'b1;
      res.stamp = t;
      if (cmd_phase == PH_LED_END) begin
        res.accepted = 1'b1;
        res.command_kind = tcd_pkg::KIND_LED;
        res.value = 32'(lamp_idx) * 32'd2 + 32'(lamp_state);
      end else if (cmd_phase == PH_TEST_NUM || cmd_phase == PH_ROT_NUM ||
                   cmd_phase == PH_NUM_DONE) begin
        if (acc_sum != 32'd0) begin
          res.accepted = 1'b1;
          if (is_test) begin
            res.command_kind = tcd_pkg::KIND_TEST;
            res.value = acc_sum;
          end else begin
            res.command_kind = tcd_pkg::KIND_ROTATE;
            res.value = neg_sign ? 32'd0 - acc_sum : acc_sum;
          end
        end
      end
      clear_parse();
      return;
    end
    case (cmd_phase)
      PH_FIRST: begin
        prefix_pos = 1;
        if (c == tcd_pkg::CH_L) cmd_phase = PH_LED_PRE;
        else if (c == tcd_pkg::CH_T) cmd_phase = PH_TEST_PRE;
        else if (c == tcd_pkg::CH_R) cmd_phase = PH_ROT_PRE;
        else cmd_phase = PH_REJECT;
      end
      PH_LED_PRE: match_prefix(c, "led ", PH_LED_DIGIT);
      PH_TEST_PRE: begin
        is_test = 1'b1;
        match_prefix(c, "test ", PH_TEST_NUM);
      end
      PH_ROT_PRE: match_prefix(c, "rotate ", PH_ROT_SIGN);
      PH_LED_DIGIT: begin
        if (num_char(c)) begin
          lamp_idx = 4'(c - tcd_pkg::CH_ZERO);
          cmd_phase = PH_LED_SPACE;
        end else begin
          cmd_phase = PH_REJECT;
        end
      end
      PH_LED_SPACE: cmd_phase = (c == tcd_pkg::CH_SPACE) ? PH_LED_WORD : PH_REJECT;
      PH_LED_WORD: cmd_phase = (c == tcd_pkg::CH_O) ? PH_LED_O : PH_REJECT;
      PH_LED_O: begin
        if (c == tcd_pkg::CH_N) begin
          lamp_state = 1'b1;
          cmd_phase = PH_LED_END;
        end else if (c == tcd_pkg::CH_F) begin
          cmd_phase = PH_LED_OF;
        end else begin
          cmd_phase = PH_REJECT;
        end
      end
      PH_LED_OF: begin
        if (c == tcd_pkg::CH_F) begin
          lamp_state = 1'b0;
          cmd_phase = PH_LED_END;
        end else begin
          cmd_phase = PH_REJECT;
        end
      end
      PH_LED_END: cmd_phase = PH_REJECT;
      PH_TEST_NUM: take_digit(c, tcd_pkg::TEST_DIGIT_LIMIT);
      PH_ROT_SIGN: begin
        if (c == tcd_pkg::CH_MINUS) begin
          neg_sign = 1'b1;
          cmd_phase = PH_ROT_NUM;
        end else if (num_char(c)) begin
          cmd_phase = PH_ROT_NUM;
          take_digit(c, tcd_pkg::ROTATE_DIGIT_LIMIT);
        end else begin
          cmd_phase = PH_REJECT;
        end
      end
      PH_ROT_NUM: take_digit(c, tcd_pkg::ROTATE_DIGIT_LIMIT);
      PH_NUM_DONE: ;
      default: cmd_phase = PH_REJECT;
    endcase
  endfunction

  function automatic void push_text(ref logic [7:0] line[$], input string s);
    for (int k = 0; k < s.len(); k++) line.push_back(s[k]);
  endfunction

  function automatic logic [7:0] digit_char(bit zero);
    return zero ? tcd_pkg::CH_ZERO : tcd_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic void build_command(ref logic [7:0] line[$]);
    bit zero;
    int n;
    line.delete();
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(0, 8);
      repeat (n) line.push_back(8'($urandom_range(1, 255)));
      return;
    end
    zero = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 2))
      0: begin
        push_text(line, "led ");
        line.push_back(digit_char(1'b0));
        push_text(line, $urandom_range(0, 1) ? " on" : " off");
      end
      1: begin
        push_text(line, "test ");
        n = $urandom_range(1, 9);
        repeat (n) line.push_back(digit_char(zero));
      end
      default: begin
        push_text(line, "rotate ");
        if ($urandom_range(0, 2) == 0) line.push_back(tcd_pkg::CH_MINUS);
        n = $urandom_range(0, 11);
        repeat (n) line.push_back(digit_char(zero));
      end
    endcase
    if ($urandom_range(0, 4) == 0)
      line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(1, 255));
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) line.push_back(8'($urandom_range(1, 255)));
    end
    if ($urandom_range(0, 9) == 0)
      line = line[0:$urandom_range(0, line.size() - 1)];
  endfunction

  task automatic send_char(input logic [7:0] c, input bit typed,
                           input tcd_pkg::result_t typed_res);
    int               gap;
    logic [31:0]      t;
    bit               emits;
    tcd_pkg::result_t res;
    gap = (tx_quiet || hold_off) ? 0 : $urandom_range(0, 9);
    case ($urandom_range(0, 7))
      0: t = '0;
      1: t = '1;
      default: t = $urandom();
    endcase
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code <= c;
    tick_time <= t;
    do @(posedge clk); while (char_stall !== 1'b0);
    decode_char(c, t, emits, res);
    if (emits) begin
      if (typed) begin
        res.accepted = typed_res.accepted;
        res.command_kind = typed_res.command_kind;
        res.value = typed_res.value;
      end
      awaited_replies.push_back(res);
    end
    chars_sent++;
  endtask

  task automatic send_command(input logic [7:0] line[$], input bit typed,
                              input tcd_pkg::result_t typed_res);
    if ($urandom_range(0, 7) == 0) tx_quiet = !tx_quiet;
    foreach (line[i]) send_char(line[i], 1'b0, REJECTED);
    send_char(tcd_pkg::CH_NUL, typed, typed_res);
    commands_sent++;
  endtask

  initial begin : stimulus
    logic [7:0] line[$];
    int         base;
    directed_rows = '{
      '{"",                   1'b1, REJECTED},
      '{"led 0 off",          1'b1, accepted_reply(tcd_pkg::KIND_LED, 32'd0)},
      '{"led 9 on",           1'b1, accepted_reply(tcd_pkg::KIND_LED, 32'd19)},
      '{"led 3 on ",          1'b1, REJECTED},
      '{"led x on",           1'b1, REJECTED},
      '{"led 5 of",           1'b1, REJECTED},
      '{"test 0000000",       1'b1, REJECTED},
      '{"test 9999999",       1'b1, accepted_reply(tcd_pkg::KIND_TEST, 32'd9999999)},
      '{"test 123456789z",    1'b0, REJECTED},
      '{"test",               1'b1, REJECTED},
      '{"rotate -",           1'b1, REJECTED},
      '{"rotate 4294967295",  1'b1, accepted_reply(tcd_pkg::KIND_ROTATE, 32'hffff_ffff)},
      '{"rotate -1",          1'b1, accepted_reply(tcd_pkg::KIND_ROTATE, 32'hffff_ffff)},
      '{"rotate 4294967296",  1'b1, REJECTED},
      '{"rotate -2147483648", 1'b0, REJECTED},
      '{"rotate 98765432109", 1'b0, REJECTED},
      '{"rotate q",           1'b1, REJECTED},
      '{"rotate 12ab",        1'b0, REJECTED}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[r]) begin
      line.delete();
      push_text(line, directed_rows[r].text);
      send_command(line, directed_rows[r].typed, directed_rows[r].reply);
    end
    base = chars_sent;
    while (chars_sent - base < RANDOM_CHARS) begin
      if (chars_sent - base > 150) pressure_req = 1'b1;
      build_command(line);
      send_command(line, 1'b0, REJECTED);
    end
    char_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d characters as %0d commands; %0d replies checked, %0d accepted",
             chars_sent, commands_sent, replies_seen, replies_ok);
    $display("Accepted by kind: led %0d, test %0d, rotate %0d; %0d failures",
             kind_seen[tcd_pkg::KIND_LED], kind_seen[tcd_pkg::KIND_TEST],
             kind_seen[tcd_pkg::KIND_ROTATE], fail_count);
    if (fail_count == 0 && awaited_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : reply_check
    int               wait_left;
    bit               rx_quiet;
    tcd_pkg::result_t want;
    wait_left = 0;
    rx_quiet = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid === 1'b1 && !result_stall) begin
        replies_seen++;
        if (awaited_replies.size() == 0) begin
          fail_count++;
          if (reports < 10) begin
            reports++;
            $display("unexpected reply: accepted %0b kind %0d value %h stamp %h",
                     accepted, command_kind, value, stamp);
          end
        end else begin
          want = awaited_replies.pop_front();
          if (want.accepted) begin
            replies_ok++;
            kind_seen[want.command_kind]++;
          end
          if (accepted !== want.accepted || command_kind !== want.command_kind ||
              value !== want.value || stamp !== want.stamp) begin
            fail_count++;
            if (reports < 10) begin
              reports++;
              $display("reply mismatch: expected %0b/%0d/%h/%h, got %0b/%0d/%h/%h",
                       want.accepted, want.command_kind, want.value, want.stamp,
                       accepted, command_kind, value, stamp);
            end
          end
        end
        if ($urandom_range(0, 7) == 0) rx_quiet = !rx_quiet;
        wait_left = rx_quiet ? 0 : $urandom_range(0, 9);
      end
      if (hold_off || wait_left > 0) begin
        result_stall <= 1'b1;
        if (wait_left > 0) wait_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin : pressure_hold
    wait (pressure_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #4_000_000;
    $display("timeout with %0d replies outstanding", awaited_replies.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
